/* rtl/core/msitt_pkg.sv */
// ----------------------------------------------------------------------------
// msitt_pkg
// Shared constants, codes and controller/datapath interface types for the
// interval timer table.
// ----------------------------------------------------------------------------
package msitt_pkg;

	localparam int SLOTS = 64;
	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [39:0] DELAY_MAX = 40'd1000000000000;
	localparam logic [5:0] CAP_RESET = 6'd16;

	// input functions
	localparam logic [2:0] FN_ARM_ONE = 3'd0;
	localparam logic [2:0] FN_ARM_REP = 3'd1;
	localparam logic [2:0] FN_CANCEL  = 3'd2;
	localparam logic [2:0] FN_TICK    = 3'd3;
	localparam logic [2:0] FN_COUNT   = 3'd4;
	localparam logic [2:0] FN_CLEAR   = 3'd5;

	// result kinds
	localparam logic [2:0] K_ARM    = 3'd0;
	localparam logic [2:0] K_CANCEL = 3'd1;
	localparam logic [2:0] K_COUNT  = 3'd2;
	localparam logic [2:0] K_FIRED  = 3'd3;
	localparam logic [2:0] K_TICK   = 3'd4;
	localparam logic [2:0] K_CLEAR  = 3'd5;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic load;
		logic arm_step;
		logic cnt_step;
		logic tk_rd;
		logic tk_add;
		logic tk_eval;
		logic reply;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       out_free;
		logic       idx_last;
		logic       arm_done;
		logic       ev_stall;
	} stat_t;

	function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [39:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {25'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

endpackage

/* rtl/core/msitt_ctrl.sv */
// ----------------------------------------------------------------------------
// msitt_ctrl
// Sequencer: dispatches each item and walks the slot scans.
// ----------------------------------------------------------------------------
module msitt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  msitt_pkg::stat_t st,
	output msitt_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_ARM, S_CNT, S_TRD, S_TADD, S_TEVAL, S_REPLY
	} state_t;

	state_t state_q;
	logic   acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.load     = acc;
		cmd.arm_step = (state_q == S_ARM);
		cmd.cnt_step = (state_q == S_CNT);
		cmd.tk_rd    = (state_q == S_TRD);
		cmd.tk_add   = (state_q == S_TADD);
		cmd.tk_eval  = (state_q == S_TEVAL);
		cmd.reply    = (state_q == S_REPLY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						case (st.func)
							msitt_pkg::FN_ARM_ONE, msitt_pkg::FN_ARM_REP: state_q <= S_ARM;
							msitt_pkg::FN_CANCEL: state_q <= S_REPLY;
							msitt_pkg::FN_TICK: state_q <= S_TRD;
							msitt_pkg::FN_COUNT, msitt_pkg::FN_CLEAR: state_q <= S_CNT;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_ARM: begin
					if (st.arm_done) state_q <= S_REPLY;
				end
				S_CNT: begin
					if (st.idx_last) state_q <= S_REPLY;
				end
				S_TRD: state_q <= S_TADD;
				S_TADD: state_q <= S_TEVAL;
				S_TEVAL: begin
					if (!st.ev_stall) state_q <= st.idx_last ? S_REPLY : S_TRD;
				end
				S_REPLY: begin
					if (st.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/msitt_dp.sv */
// ----------------------------------------------------------------------------
// msitt_dp
// Slot storage, scan index, counters and the result register.
// ----------------------------------------------------------------------------
module msitt_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [2:0]       func,
	input  logic [39:0]      delay_len,
	input  logic [7:0]       slot_id,
	input  logic [63:0]      now_ms,
	input  logic             cfg_valid,
	input  logic [5:0]       max_fires_per_tick,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [2:0]       kind,
	output logic [6:0]       timer_id,
	output logic [1:0]       status,
	output logic [6:0]       active_count,
	output logic             last,
	input  msitt_pkg::cmd_t  cmd,
	output msitt_pkg::stat_t st
);

	localparam int IW = msitt_pkg::IDX_W;

	logic [63:0] due_mem [msitt_pkg::SLOTS];
	logic [39:0] per_mem [msitt_pkg::SLOTS];
	logic [msitt_pkg::SLOTS-1:0] active_q, pending_q, rep_q;

	logic        seen_q;
	logic [63:0] last_tick_q;
	logic [5:0]  cap_q;
	logic [IW-1:0] idx_q;
	logic [6:0]  cnt_q;
	logic [2:0]  func_q;
	logic [39:0] delay_q;
	logic [7:0]  sid_q;
	logic        bad_q;
	logic [1:0]  stat_q;
	logic [6:0]  slot_q;
	logic [63:0] due_rd_q, sum_q;
	logic [39:0] per_rd_q;

	logic out_free, idx_last, anchor, pend_eff, fire;
	logic [63:0] due_eff;
	logic cancel_hit;
	logic [IW-1:0] sid_idx;
	logic [2:0] reply_kind;

	assign out_free = !out_valid || out_ready;
	assign idx_last = (idx_q == IW'(msitt_pkg::SLOTS - 1));

	// first tick anchors pending timers to now plus delay
	assign anchor   = !seen_q && active_q[idx_q] && pending_q[idx_q];
	assign pend_eff = pending_q[idx_q] && !anchor;
	assign due_eff  = anchor ? sum_q : due_rd_q;
	assign fire     = active_q[idx_q] && !pend_eff && (last_tick_q >= due_eff)
	                  && (cnt_q < {1'b0, cap_q});

	assign sid_idx    = IW'(sid_q - 8'd1);
	assign cancel_hit = (sid_q != 8'd0) && ({1'b0, sid_q} <= 9'(msitt_pkg::SLOTS))
	                    && active_q[sid_idx];

	always_comb begin
		case (func_q)
			msitt_pkg::FN_CANCEL: reply_kind = msitt_pkg::K_CANCEL;
			msitt_pkg::FN_TICK:   reply_kind = msitt_pkg::K_TICK;
			msitt_pkg::FN_COUNT:  reply_kind = msitt_pkg::K_COUNT;
			msitt_pkg::FN_CLEAR:  reply_kind = msitt_pkg::K_CLEAR;
			default:              reply_kind = msitt_pkg::K_ARM;
		endcase
	end

	always_comb begin
		st.func     = func;
		st.out_free = out_free;
		st.idx_last = idx_last;
		st.arm_done = bad_q || !active_q[idx_q] || idx_last;
		st.ev_stall = fire && !out_free;
	end

	// slot memories, read registered
	always_ff @(posedge clk) begin
		if (cmd.tk_rd) begin
			due_rd_q <= due_mem[idx_q];
			per_rd_q <= per_mem[idx_q];
		end
		if (cmd.tk_add) sum_q <= msitt_pkg::sat_add(last_tick_q, per_rd_q);
		if (cmd.arm_step && !bad_q && !active_q[idx_q]) begin
			per_mem[idx_q] <= delay_q;
			due_mem[idx_q] <= seen_q ? msitt_pkg::sat_add(last_tick_q, delay_q) : 64'd0;
		end
		if (cmd.tk_eval && !st.ev_stall && (anchor || (fire && rep_q[idx_q])))
			due_mem[idx_q] <= sum_q;
		if (cmd.arm_step && !bad_q && !active_q[idx_q])
			rep_q[idx_q] <= func_q[0];
		if (cmd.load) begin
			func_q  <= func;
			delay_q <= delay_len;
			sid_q   <= slot_id;
			bad_q   <= (delay_len == 40'd0) || (delay_len > msitt_pkg::DELAY_MAX);
		end
		if (cmd.arm_step) begin
			if (bad_q) begin
				stat_q <= msitt_pkg::ST_BAD;
				slot_q <= 7'd0;
			end else if (!active_q[idx_q]) begin
				stat_q <= msitt_pkg::ST_OK;
				slot_q <= 7'({1'b0, idx_q} + 1);
			end else begin
				stat_q <= msitt_pkg::ST_FULL;
				slot_q <= 7'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			pending_q   <= '0;
			seen_q      <= 1'b0;
			last_tick_q <= 64'd0;
			cap_q       <= msitt_pkg::CAP_RESET;
			idx_q       <= '0;
			cnt_q       <= 7'd0;
			out_valid   <= 1'b0;
			kind        <= 3'd0;
			timer_id    <= 7'd0;
			status      <= 2'd0;
			active_count <= 7'd0;
			last        <= 1'b0;
		end else begin
			if (cfg_valid) cap_q <= max_fires_per_tick;
			if (out_ready) out_valid <= 1'b0;

			if (cmd.load) begin
				idx_q <= '0;
				cnt_q <= 7'd0;
				if (func == msitt_pkg::FN_TICK) last_tick_q <= now_ms;
			end

			if (cmd.arm_step) begin
				if (!bad_q && !active_q[idx_q]) begin
					active_q[idx_q]  <= 1'b1;
					pending_q[idx_q] <= !seen_q;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end

			if (cmd.cnt_step) begin
				if (active_q[idx_q]) begin
					cnt_q <= cnt_q + 7'd1;
					if (func_q == msitt_pkg::FN_CLEAR) active_q[idx_q] <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
			end

			if (cmd.tk_eval && !st.ev_stall) begin
				if (anchor) pending_q[idx_q] <= 1'b0;
				if (fire) begin
					cnt_q <= cnt_q + 7'd1;
					if (!rep_q[idx_q]) active_q[idx_q] <= 1'b0;
					out_valid    <= 1'b1;
					kind         <= msitt_pkg::K_FIRED;
					timer_id     <= 7'({1'b0, idx_q} + 1);
					status       <= msitt_pkg::ST_OK;
					active_count <= cnt_q + 7'd1;
					last         <= 1'b0;
				end
				idx_q <= idx_q + 1'b1;
				if (idx_last) seen_q <= 1'b1;
			end

			if (cmd.reply && out_free) begin
				out_valid    <= 1'b1;
				kind         <= reply_kind;
				last         <= 1'b1;
				timer_id     <= 7'd0;
				status       <= msitt_pkg::ST_OK;
				active_count <= 7'd0;
				case (func_q)
					msitt_pkg::FN_ARM_ONE, msitt_pkg::FN_ARM_REP: begin
						timer_id <= slot_q;
						status   <= stat_q;
					end
					msitt_pkg::FN_CANCEL: begin
						if (cancel_hit) begin
							active_q[sid_idx] <= 1'b0;
							timer_id <= sid_q[6:0];
						end else begin
							status <= msitt_pkg::ST_MISS;
						end
					end
					default: active_count <= cnt_q;
				endcase
			end
		end
	end

endmodule

/* rtl/core/multi_slot_interval_timer_table_top.sv */
// ----------------------------------------------------------------------------
// multi_slot_interval_timer_table_top
// Table of 64 one-shot and repeating timer slots driven by command items.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid/in_ready (func, delay_len, slot_id, now_ms),
// results leave on out_valid/out_ready; last marks the final result of an
// item. The cap on fires per tick is written on cfg_valid/cfg_ready; the
// user must write it only while the block is idle, and the block has no
// check for this; cfg_ready is always high. One item at a time. Arm walks
// one slot a cycle in search of the lowest free slot; count and clear walk
// every slot; a tick takes each slot through a memory read, a saturating
// add, and a compare and update. Unknown func codes are dropped.
// Results sit in one output register; when the receiver stalls, the scan
// waits on the slot that fires and resumes when the register frees up.
// Reset clears all timers, the first-tick flag, the tick time and sets the
// fire cap to 16; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_slot_interval_timer_table_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [39:0] delay_len,
	input  logic [7:0]  slot_id,
	input  logic [63:0] now_ms,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  max_fires_per_tick,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  kind,
	output logic [6:0]  timer_id,
	output logic [1:0]  status,
	output logic [6:0]  active_count,
	output logic        last
);

	msitt_pkg::cmd_t  cmd;
	msitt_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	msitt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	msitt_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.func               (func),
		.delay_len          (delay_len),
		.slot_id            (slot_id),
		.now_ms             (now_ms),
		.cfg_valid          (cfg_valid),
		.max_fires_per_tick (max_fires_per_tick),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.kind               (kind),
		.timer_id           (timer_id),
		.status             (status),
		.active_count       (active_count),
		.last               (last),
		.cmd                (cmd),
		.st                 (st)
	);

endmodule

/* verif/multi_slot_interval_timer_table_top_test.sv */
// ----------------------------------------------------------------------------
// multi_slot_interval_timer_table_top_test
// Self-checking bench for the timer slot table: directed rows and cases, then
// random command streams, every result checked against a row or an in-bench
// slot model, with random idling on both channels and fire-cap changes.
// ----------------------------------------------------------------------------
module multi_slot_interval_timer_table_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;

	typedef struct packed {
		logic [2:0] kind;
		logic [6:0] id;
		logic [1:0] st;
		logic [6:0] cnt;
		logic       last;
	} reply_t;

	typedef struct {
		logic [2:0]  f;
		logic [39:0] d;
		logic [7:0]  s;
		logic [63:0] n;
		bit          typed;
		reply_t      r;
	} row_t;

	logic        clk, arst_n;
	logic        in_valid, in_ready;
	logic [2:0]  func;
	logic [39:0] delay_len;
	logic [7:0]  slot_id;
	logic [63:0] now_ms;
	logic        cfg_valid, cfg_ready;
	logic [5:0]  max_fires_per_tick;
	logic        out_valid, out_ready;
	logic [2:0]  kind;
	logic [6:0]  timer_id;
	logic [1:0]  status;
	logic [6:0]  active_count;
	logic        last;

	multi_slot_interval_timer_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .delay_len(delay_len), .slot_id(slot_id), .now_ms(now_ms),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.max_fires_per_tick(max_fires_per_tick),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .timer_id(timer_id), .status(status),
		.active_count(active_count), .last(last)
	);

	// slot model
	logic [63:0] due_at[msitt_pkg::SLOTS];
	logic [39:0] period_ms[msitt_pkg::SLOTS];
	bit          repeating[msitt_pkg::SLOTS], pending[msitt_pkg::SLOTS];
	bit          armed[msitt_pkg::SLOTS];
	bit          ticked;
	logic [63:0] tick_time;
	logic [5:0]  fire_cap;

	reply_t      pending_replies[$];
	int          errors;
	bit          hold_req, quiet;
	logic [63:0] tnow;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [39:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {25'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic reply_t mk(logic [2:0] k, logic [6:0] id, logic [1:0] st,
			logic [6:0] cnt);
		reply_t r;
		r.kind = k; r.id = id; r.st = st; r.cnt = cnt; r.last = 1'b1;
		return r;
	endfunction

	task automatic report(string what);
		errors++;
		$display("mismatch @%0t: %s", $realtime, what);
	endtask

	// works out the replies of one accepted item and updates the slot model
	task automatic predict_replies(logic [2:0] f, logic [39:0] d, logic [7:0] s,
			logic [63:0] n);
		int slot;
		int fired;
		reply_t r;
		slot = -1;
		fired = 0;
		case (f)
			msitt_pkg::FN_ARM_ONE, msitt_pkg::FN_ARM_REP: begin
				if (d == 40'd0 || d > msitt_pkg::DELAY_MAX) begin
					pending_replies.push_back(mk(msitt_pkg::K_ARM, 7'd0, msitt_pkg::ST_BAD,
						7'd0));
				end else begin
					for (int i = 0; i < msitt_pkg::SLOTS; i++)
						if (!armed[i] && slot < 0) slot = i;
					if (slot < 0) begin
						pending_replies.push_back(mk(msitt_pkg::K_ARM, 7'd0,
							msitt_pkg::ST_FULL, 7'd0));
					end else begin
						period_ms[slot] = d;
						repeating[slot] = (f == msitt_pkg::FN_ARM_REP);
						pending[slot] = !ticked;
						due_at[slot] = ticked ? add_sat(tick_time, d) : 64'd0;
						armed[slot] = 1;
						pending_replies.push_back(mk(msitt_pkg::K_ARM, 7'(slot + 1),
							msitt_pkg::ST_OK, 7'd0));
					end
				end
			end
			msitt_pkg::FN_CANCEL: begin
				if (s >= 1 && s <= msitt_pkg::SLOTS && armed[s - 1]) begin
					armed[s - 1] = 0;
					pending_replies.push_back(mk(msitt_pkg::K_CANCEL, s[6:0],
						msitt_pkg::ST_OK, 7'd0));
				end else begin
					pending_replies.push_back(mk(msitt_pkg::K_CANCEL, 7'd0,
						msitt_pkg::ST_MISS, 7'd0));
				end
			end
			msitt_pkg::FN_TICK: begin
				tick_time = n;
				if (!ticked) begin
					ticked = 1;
					// first tick anchors every waiting timer to this tick
					for (int i = 0; i < msitt_pkg::SLOTS; i++)
						if (armed[i] && pending[i]) begin
							pending[i] = 0;
							due_at[i] = add_sat(n, period_ms[i]);
						end
				end
				for (int i = 0; i < msitt_pkg::SLOTS; i++) begin
					if (fired < fire_cap && armed[i] && !pending[i] && n >= due_at[i]) begin
						fired++;
						r = mk(msitt_pkg::K_FIRED, 7'(i + 1), msitt_pkg::ST_OK, 7'(fired));
						r.last = 0;
						pending_replies.push_back(r);
						if (repeating[i]) due_at[i] = add_sat(n, period_ms[i]);
						else armed[i] = 0;
					end
				end
				pending_replies.push_back(mk(msitt_pkg::K_TICK, 7'd0, msitt_pkg::ST_OK,
					7'(fired)));
			end
			msitt_pkg::FN_COUNT, msitt_pkg::FN_CLEAR: begin
				for (int i = 0; i < msitt_pkg::SLOTS; i++)
					if (armed[i]) begin
						fired++;
						if (f == msitt_pkg::FN_CLEAR) armed[i] = 0;
					end
				pending_replies.push_back(mk(f == msitt_pkg::FN_COUNT ? msitt_pkg::K_COUNT
					: msitt_pkg::K_CLEAR, 7'd0, msitt_pkg::ST_OK, 7'(fired)));
			end
			default: ;
		endcase
	endtask

	task automatic send_item(logic [2:0] f, logic [39:0] d, logic [7:0] s, logic [63:0] n,
			bit typed = 0, reply_t r = '0);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1;
		func <= f; delay_len <= d; slot_id <= s; now_ms <= n;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_replies(f, d, s, n);
		if (typed) pending_replies[$] = r;
	endtask

	// block is idle: nothing outstanding and any silent item long finished
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (220) @(posedge clk);
	endtask

	task automatic write_cap(logic [5:0] v);
		cfg_valid <= 1;
		max_fires_per_tick <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		fire_cap = v;
		cfg_valid <= 0;
	endtask

	task automatic random_item();
		int r;
		logic [39:0] wide;
		wide = {$urandom(), 8'($urandom())};
		r = $urandom_range(0, 99);
		if (r < 40) begin
			send_item(3'($urandom_range(0, 1)),
				$urandom_range(0, 9) == 0 ? wide : 40'($urandom_range(1, 3000)),
				8'($urandom()), {$urandom(), $urandom()});
		end else if (r < 62) begin
			tnow = tnow + 64'($urandom_range(0, 2500));
			send_item(msitt_pkg::FN_TICK, wide, 8'($urandom()), tnow);
		end else if (r < 80) begin
			send_item(msitt_pkg::FN_CANCEL, wide, 8'($urandom_range(0, 70)),
				{$urandom(), $urandom()});
		end else if (r < 95) begin
			send_item(msitt_pkg::FN_COUNT, wide, 8'($urandom()), {$urandom(), $urandom()});
		end else begin
			send_item(msitt_pkg::FN_CLEAR, wide, 8'($urandom()), {$urandom(), $urandom()});
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 0;
		forever begin
			if (hold_req) begin
				out_ready <= 0;
				repeat (400) @(posedge clk);
				hold_req = 0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				out_ready <= 1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				report($sformatf("unexpected item kind %0d id %0d", kind, timer_id));
			end else begin
				want = pending_replies.pop_front();
				if (kind !== want.kind)
					report($sformatf("kind %0d, want %0d", kind, want.kind));
				if (timer_id !== want.id)
					report($sformatf("timer_id %0d, want %0d", timer_id, want.id));
				if (status !== want.st)
					report($sformatf("status %0d, want %0d", status, want.st));
				if (active_count !== want.cnt)
					report($sformatf("active_count %0d, want %0d", active_count, want.cnt));
				if (last !== want.last)
					report($sformatf("last %0d, want %0d", last, want.last));
			end
		end
	end

	initial begin
		for (int c = 0; c < CYCLE_LIMIT; c++) @(posedge clk);
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		row_t rows[$];
		row_t w;
		int done;
		arst_n = 0;
		in_valid = 0; func = 3'd0; delay_len = 40'd0; slot_id = 8'd0; now_ms = 64'd0;
		cfg_valid = 0; max_fires_per_tick = msitt_pkg::CAP_RESET;
		errors = 0; hold_req = 0; quiet = 0; tnow = 64'd0;
		for (int i = 0; i < msitt_pkg::SLOTS; i++) begin
			due_at[i] = 64'd0; period_ms[i] = 40'd0;
			repeating[i] = 0; pending[i] = 0; armed[i] = 0;
		end
		ticked = 0; tick_time = 64'd0; fire_cap = msitt_pkg::CAP_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		write_cap(msitt_pkg::CAP_RESET);

		rows = '{
			'{msitt_pkg::FN_COUNT, 40'd0, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_COUNT, 7'd0, msitt_pkg::ST_OK, 7'd0)},
			'{msitt_pkg::FN_CANCEL, 40'd0, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_CANCEL, 7'd0, msitt_pkg::ST_MISS, 7'd0)},
			'{msitt_pkg::FN_CANCEL, 40'd0, 8'd255, 64'd0, 1'b1,
				mk(msitt_pkg::K_CANCEL, 7'd0, msitt_pkg::ST_MISS, 7'd0)},
			'{msitt_pkg::FN_ARM_ONE, 40'd0, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_ARM, 7'd0, msitt_pkg::ST_BAD, 7'd0)},
			'{msitt_pkg::FN_ARM_REP, msitt_pkg::DELAY_MAX + 40'd1, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_ARM, 7'd0, msitt_pkg::ST_BAD, 7'd0)},
			'{msitt_pkg::FN_ARM_ONE, {40{1'b1}}, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_ARM, 7'd0, msitt_pkg::ST_BAD, 7'd0)},
			'{msitt_pkg::FN_ARM_ONE, 40'd1, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_ARM, 7'd1, msitt_pkg::ST_OK, 7'd0)},
			'{msitt_pkg::FN_ARM_REP, msitt_pkg::DELAY_MAX, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_ARM, 7'd2, msitt_pkg::ST_OK, 7'd0)},
			'{msitt_pkg::FN_ARM_REP, 40'd5, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_ARM, 7'd3, msitt_pkg::ST_OK, 7'd0)},
			'{3'd6, {40{1'b1}}, 8'hff, {64{1'b1}}, 1'b0, '0},
			'{3'd7, 40'd0, 8'd0, 64'd0, 1'b0, '0},
			'{msitt_pkg::FN_TICK, 40'd0, 8'd0, 64'd100, 1'b0, '0},
			'{msitt_pkg::FN_TICK, 40'd0, 8'd0, 64'd101, 1'b0, '0},
			'{msitt_pkg::FN_TICK, 40'd0, 8'd0, 64'd106, 1'b0, '0},
			'{msitt_pkg::FN_CANCEL, 40'd0, 8'd2, 64'd0, 1'b0, '0},
			'{msitt_pkg::FN_CANCEL, 40'd0, 8'd2, 64'd0, 1'b1,
				mk(msitt_pkg::K_CANCEL, 7'd0, msitt_pkg::ST_MISS, 7'd0)},
			'{msitt_pkg::FN_CANCEL, 40'd0, 8'd64, 64'd0, 1'b1,
				mk(msitt_pkg::K_CANCEL, 7'd0, msitt_pkg::ST_MISS, 7'd0)},
			'{msitt_pkg::FN_TICK, 40'd0, 8'd0, {64{1'b1}}, 1'b0, '0},
			'{msitt_pkg::FN_TICK, 40'd0, 8'd0, {64{1'b1}}, 1'b0, '0},
			'{msitt_pkg::FN_ARM_ONE, 40'd7, 8'd0, 64'd0, 1'b0, '0},
			'{msitt_pkg::FN_COUNT, 40'd0, 8'd0, 64'd0, 1'b0, '0},
			'{msitt_pkg::FN_CLEAR, 40'd0, 8'd0, 64'd0, 1'b0, '0},
			'{msitt_pkg::FN_COUNT, 40'd0, 8'd0, 64'd0, 1'b1,
				mk(msitt_pkg::K_COUNT, 7'd0, msitt_pkg::ST_OK, 7'd0)}
		};
		foreach (rows[i]) begin
			w = rows[i];
			send_item(w.f, w.d, w.s, w.n, w.typed, w.r);
		end
		drain();

		// fill the table past full, then one tick firing a crowd while the
		// receiver holds off and the input backs up behind it
		write_cap(6'd63);
		tnow = 64'd1000;
		send_item(msitt_pkg::FN_TICK, 40'd0, 8'd0, tnow);
		for (int i = 0; i < msitt_pkg::SLOTS + 2; i++)
			send_item(3'($urandom_range(0, 1)), 40'($urandom_range(1, 40)), 8'd0, 64'd0);
		drain();
		hold_req = 1;
		tnow = tnow + 64'd50;
		send_item(msitt_pkg::FN_TICK, 40'd0, 8'd0, tnow);
		send_item(msitt_pkg::FN_COUNT, 40'd0, 8'd0, 64'd0);
		send_item(msitt_pkg::FN_CANCEL, 40'd0, 8'd1, 64'd0);
		drain();

		write_cap(6'd0);
		tnow = tnow + 64'd100;
		send_item(msitt_pkg::FN_TICK, 40'd0, 8'd0, tnow);
		drain();
		write_cap(6'd1);
		repeat (3) begin
			tnow = tnow + 64'd100;
			send_item(msitt_pkg::FN_TICK, 40'd0, 8'd0, tnow);
		end
		drain();

		done = 0;
		while (done < 82) begin
			if (done % 40 == 39) begin
				drain();
				write_cap(6'($urandom_range(1, 63)));
			end
			if (done == 60) quiet = 1;
			if ($urandom_range(0, 29) == 0) begin
				send_item(3'($urandom_range(6, 7)), {$urandom(), 8'($urandom())},
					8'($urandom()), {$urandom(), $urandom()});
			end else begin
				random_item();
				done++;
			end
		end
		drain();

		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
